FILE: src/ufr_pkg.sv
// Shared types and constants for the UBX frame receiver.
// No dependencies; imported by every module in src.
package ufr_pkg;

	localparam int MAX_BODY_DEF = 1024;
	localparam int BYTE_W       = 8;
	localparam int LEN_CFG_W    = 11;
	localparam int IDX_W        = 10;
	localparam int ADDR_W       = 5;
	localparam int DATA_W       = 32;
	localparam int MIN_BODY     = 4;

	localparam logic [BYTE_W-1:0]    SYNC_FIRST_RST   = 8'hB5;
	localparam logic [BYTE_W-1:0]    SYNC_SECOND_RST  = 8'h62;
	localparam logic [BYTE_W-1:0]    WANTED_CLASS_RST = 8'h01;
	localparam logic [BYTE_W-1:0]    WANTED_ID_RST    = 8'h07;
	localparam logic [LEN_CFG_W-1:0] BODY_LENGTH_RST  = 11'd96;

	typedef enum logic [2:0] {
		REG_SYNC_FIRST   = 3'd0,
		REG_SYNC_SECOND  = 3'd1,
		REG_WANTED_CLASS = 3'd2,
		REG_WANTED_ID    = 3'd3,
		REG_BODY_LENGTH  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0]    sync_first;
		logic [BYTE_W-1:0]    sync_second;
		logic [BYTE_W-1:0]    wanted_class;
		logic [BYTE_W-1:0]    wanted_id;
		logic [LEN_CFG_W-1:0] body_length;
	} cfg_t;

	typedef struct packed {
		logic              store_valid;
		logic [IDX_W-1:0]  store_index;
		logic [BYTE_W-1:0] store_data;
		logic              frame_good;
	} result_t;

endpackage

FILE: src/ufr_regs.sv
// APB-style configuration register file for the UBX frame receiver.
// Depends on ufr_pkg (cfg_t, register indexes, reset values).
module ufr_regs import ufr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first   <= SYNC_FIRST_RST;
			cfg_q.sync_second  <= SYNC_SECOND_RST;
			cfg_q.wanted_class <= WANTED_CLASS_RST;
			cfg_q.wanted_id    <= WANTED_ID_RST;
			cfg_q.body_length  <= BODY_LENGTH_RST;
		end else if (wr_en) begin
			case (idx)
				REG_SYNC_FIRST:   cfg_q.sync_first   <= pwdata[BYTE_W-1:0];
				REG_SYNC_SECOND:  cfg_q.sync_second  <= pwdata[BYTE_W-1:0];
				REG_WANTED_CLASS: cfg_q.wanted_class <= pwdata[BYTE_W-1:0];
				REG_WANTED_ID:    cfg_q.wanted_id    <= pwdata[BYTE_W-1:0];
				REG_BODY_LENGTH:  cfg_q.body_length  <= pwdata[LEN_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SYNC_FIRST:   prdata = DATA_W'(cfg_q.sync_first);
			REG_SYNC_SECOND:  prdata = DATA_W'(cfg_q.sync_second);
			REG_WANTED_CLASS: prdata = DATA_W'(cfg_q.wanted_class);
			REG_WANTED_ID:    prdata = DATA_W'(cfg_q.wanted_id);
			REG_BODY_LENGTH:  prdata = DATA_W'(cfg_q.body_length);
			default:          prdata = '0;
		endcase
	end

endmodule

FILE: src/ufr_parser.sv
// Frame parser: sync hunt, body offset counter, Fletcher-8 sums, checksum check.
// Depends on ufr_pkg. State advances only when upd is high.
module ufr_parser import ufr_pkg::*; #(
	parameter int MAX_BODY = MAX_BODY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd,
	input  logic [BYTE_W-1:0] rx_byte,
	input  cfg_t              cfg,
	output result_t           res
);

	localparam int K_W = $clog2(MAX_BODY + 2);
	localparam int CW  = (K_W > LEN_CFG_W) ? K_W : LEN_CFG_W;

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_SYNC1,
		ST_BODY
	} state_t;

	state_t            state_q, state_d;
	logic [K_W-1:0]    k_q, k_d;
	logic [BYTE_W-1:0] sum_a_q, sum_a_d;
	logic [BYTE_W-1:0] sum_b_q, sum_b_d;
	logic [BYTE_W-1:0] type_q, type_d;
	logic [CW-1:0]     len_ext;
	logic [K_W-1:0]    eff_len;
	logic [BYTE_W-1:0] a_new;

	// clamp configured length into [MIN_BODY, MAX_BODY]
	always_comb begin
		len_ext = CW'(cfg.body_length);
		if (len_ext < CW'(MIN_BODY))
			len_ext = CW'(MIN_BODY);
		else if (len_ext > CW'(MAX_BODY))
			len_ext = CW'(MAX_BODY);
		eff_len = K_W'(len_ext);
	end

	assign a_new = sum_a_q + rx_byte;

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		sum_a_d = sum_a_q;
		sum_b_d = sum_b_q;
		type_d  = type_q;
		res     = '0;
		case (state_q)
			ST_HUNT: begin
				if (rx_byte == cfg.sync_first)
					state_d = ST_SYNC1;
			end
			ST_SYNC1: begin
				if (rx_byte == cfg.sync_second) begin
					state_d = ST_BODY;
					k_d     = '0;
					sum_a_d = '0;
					sum_b_d = '0;
				end else begin
					state_d = ST_HUNT;
				end
			end
			ST_BODY: begin
				if (k_q < eff_len) begin
					res.store_valid = 1'b1;
					res.store_index = IDX_W'(k_q);
					res.store_data  = rx_byte;
					sum_a_d = a_new;
					sum_b_d = sum_b_q + a_new;
					k_d     = k_q + 1'b1;
					if (k_q == '0) begin
						type_d = rx_byte;
					end else if (k_q == K_W'(1)) begin
						if (type_q != cfg.wanted_class || rx_byte != cfg.wanted_id)
							state_d = ST_HUNT;
					end
				end else if (k_q == eff_len) begin
					if (rx_byte == sum_a_q)
						k_d = k_q + 1'b1;
					else
						state_d = ST_HUNT;
				end else begin
					res.frame_good = (k_q == eff_len + 1'b1) && (rx_byte == sum_b_q);
					state_d = ST_HUNT;
				end
			end
			default: state_d = ST_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			k_q     <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
			type_q  <= '0;
		end else if (upd) begin
			state_q <= state_d;
			k_q     <= k_d;
			sum_a_q <= sum_a_d;
			sum_b_q <= sum_b_d;
			type_q  <= type_d;
		end
	end

	a_store_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		res.store_valid |-> state_q == ST_BODY)
		else $error("store strobe outside frame body");

	a_k_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BODY |-> k_q <= K_W'(MAX_BODY + 1))
		else $error("body offset ran past checksum bytes");

	a_sync_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && state_q == ST_SYNC1 && rx_byte == cfg.sync_second)
		|=> (state_q == ST_BODY && k_q == '0 && sum_a_q == '0 && sum_b_q == '0))
		else $error("sums or offset not cleared after sync");

	a_good_not_store: assert property (@(posedge clk) disable iff (!arst_n)
		res.frame_good |-> !res.store_valid && state_q == ST_BODY)
		else $error("frame_good on a body byte");

endmodule

FILE: src/ubx_frame_receiver_unit.sv
// Top level of the UBX frame receiver: input register, parser, result register.
// Depends on ufr_pkg, ufr_regs, ufr_parser.

// One received byte per word on the input channel, one result word per input byte on
// the output channel. A result word passes the input register, then the result
// register; an output stall can hold it between them. A new byte is accepted every
// cycle as long as the output is not stalled; the parser's combinational checksum and
// offset update sets this one-byte-per-cycle rate. A result word carries a store
// strobe with body offset and byte for class, id, length and payload bytes, and
// frame_good on the last checksum byte of a frame whose Fletcher-8 sums match. The
// user must write configuration (sync bytes, message class/id, body length) over the
// APB port only while no byte is in flight; the block itself does not enforce this.
module ubx_frame_receiver_unit import ufr_pkg::*; #(
	parameter int MAX_BODY = MAX_BODY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              store_valid,
	output logic [IDX_W-1:0]  store_index,
	output logic [BYTE_W-1:0] store_data,
	output logic              frame_good
);

	cfg_t              cfg;
	result_t           res;
	result_t           res_s2;
	logic              valid_s1, valid_s2;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_ready;
	logic              upd;

	ufr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign out_ready = !valid_s2 || !out_stall;
	assign upd       = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= rx_byte;
	end

	ufr_parser #(
		.MAX_BODY (MAX_BODY)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (upd),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd)
			res_s2 <= res;
	end

	assign out_valid   = valid_s2;
	assign store_valid = res_s2.store_valid;
	assign store_index = res_s2.store_index;
	assign store_data  = res_s2.store_data;
	assign frame_good  = res_s2.frame_good;

endmodule

FILE: sim/ufr_frame_checker.sv
`timescale 1ns / 1ps
// Checker for ubx_frame_receiver_unit: tracks APB register writes, predicts one
// result word per accepted input byte and compares the words in order.
// Depends on ufr_pkg.
module ufr_frame_checker import ufr_pkg::*; #(
	parameter int MAX_BODY = MAX_BODY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pready,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              store_valid,
	input  logic [IDX_W-1:0]  store_index,
	input  logic [BYTE_W-1:0] store_data,
	input  logic              frame_good,
	output int                errors,
	output int                pending
);

	cfg_t              cfg;
	int unsigned       pos;
	logic [BYTE_W-1:0] ck_a;
	logic [BYTE_W-1:0] ck_b;
	logic [BYTE_W-1:0] msg_class;
	result_t           parser_out_q[$];

	initial errors = 0;
	initial pending = 0;

	// Frame parser: pos 0 hunts sync, 1 saw first sync, 2+k is body/checksum byte k.
	function automatic result_t parse_byte(logic [BYTE_W-1:0] b);
		result_t     r;
		int unsigned span;
		int unsigned k;
		r = '0;
		span = cfg.body_length;
		if (span < MIN_BODY)
			span = MIN_BODY;
		if (span > MAX_BODY)
			span = MAX_BODY;
		if (pos == 0) begin
			if (b == cfg.sync_first)
				pos = 1;
		end else if (pos == 1) begin
			if (b == cfg.sync_second) begin
				pos = 2;
				ck_a = '0;
				ck_b = '0;
			end else begin
				pos = 0;
			end
		end else begin
			k = pos - 2;
			if (k < span) begin
				r.store_valid = 1'b1;
				r.store_index = k[IDX_W-1:0];
				r.store_data = b;
				ck_a = ck_a + b;
				ck_b = ck_b + ck_a;
				pos = pos + 1;
				if (k == 0)
					msg_class = b;
				else if (k == 1 && (msg_class != cfg.wanted_class || b != cfg.wanted_id))
					pos = 0;
			end else if (k == span) begin
				pos = (b == ck_a) ? pos + 1 : 0;
			end else begin
				r.frame_good = (k == span + 1) && (b == ck_b);
				pos = 0;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			cfg = '{SYNC_FIRST_RST, SYNC_SECOND_RST, WANTED_CLASS_RST, WANTED_ID_RST,
				BODY_LENGTH_RST};
			pos = 0;
			ck_a = '0;
			ck_b = '0;
			msg_class = '0;
			parser_out_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_SYNC_FIRST:   cfg.sync_first = pwdata[BYTE_W-1:0];
					REG_SYNC_SECOND:  cfg.sync_second = pwdata[BYTE_W-1:0];
					REG_WANTED_CLASS: cfg.wanted_class = pwdata[BYTE_W-1:0];
					REG_WANTED_ID:    cfg.wanted_id = pwdata[BYTE_W-1:0];
					REG_BODY_LENGTH:  cfg.body_length = pwdata[LEN_CFG_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				parser_out_q.push_back(parse_byte(rx_byte));
			if (out_valid && !out_stall) begin
				if (parser_out_q.size() == 0) begin
					$error("result word with no input byte pending");
					errors++;
				end else begin
					want = parser_out_q.pop_front();
					if (store_valid !== want.store_valid) begin
						$error("store_valid: expected %0d, got %0d", want.store_valid,
							store_valid);
						errors++;
					end
					if (store_index !== want.store_index) begin
						$error("store_index: expected %0d, got %0d", want.store_index,
							store_index);
						errors++;
					end
					if (store_data !== want.store_data) begin
						$error("store_data: expected 0x%02h, got 0x%02h", want.store_data,
							store_data);
						errors++;
					end
					if (frame_good !== want.frame_good) begin
						$error("frame_good: expected %0d, got %0d", want.frame_good,
							frame_good);
						errors++;
					end
				end
			end
		end
		pending = parser_out_q.size();
	end

endmodule

FILE: sim/ubx_frame_receiver_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for ubx_frame_receiver_unit: builds UBX byte streams (good and
// broken frames, noise), programs registers over APB and gives the verdict.
// Depends on ufr_pkg, ubx_frame_receiver_unit and ufr_frame_checker.
module ubx_frame_receiver_unit_test;
	import ufr_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int PHASE_WORDS  = 55;
	localparam int N_PHASES     = 9;

	typedef enum {
		FRM_GOOD,
		FRM_BAD_CKA,
		FRM_BAD_CKB,
		FRM_BAD_CLASS,
		FRM_BAD_ID,
		FRM_BAD_SYNC,
		FRM_NOISE
	} frame_kind_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              store_valid;
	logic [IDX_W-1:0]  store_index;
	logic [BYTE_W-1:0] store_data;
	logic              frame_good;

	int                fail_count;
	int                words_pending;
	int                bytes_queued = 0;
	int                bytes_taken = 0;
	int                gap_pct = 0;
	int                stall_pct = 0;
	int                quiet_cycles = 0;
	logic [BYTE_W-1:0] tx_q[$];
	cfg_t              cur;
	cfg_t              phase_cfg[N_PHASES];

	ubx_frame_receiver_unit u_top (.*);

	ufr_frame_checker u_chk (.*, .errors(fail_count), .pending(words_pending));

	initial begin
		forever #10 clk = ~clk;
	end

	// Byte sender: holds a word until taken, then maybe idles.
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			bytes_taken <= bytes_taken + 1;
		if (arst_n && (!in_valid || !in_stall)) begin
			if (tx_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
				in_valid <= 1'b1;
				rx_byte <= tx_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic push_byte(logic [BYTE_W-1:0] b);
		tx_q.push_back(b);
		bytes_queued++;
	endtask

	// Wait until every byte is taken and every result word has come back.
	task automatic drain();
		do
			@(posedge clk);
		while (bytes_taken != bytes_queued || words_pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t r, logic [DATA_W-1:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic program_regs(cfg_t c);
		cfg_write(REG_SYNC_FIRST, DATA_W'(c.sync_first));
		cfg_write(REG_SYNC_SECOND, DATA_W'(c.sync_second));
		cfg_write(REG_WANTED_CLASS, DATA_W'(c.wanted_class));
		cfg_write(REG_WANTED_ID, DATA_W'(c.wanted_id));
		cfg_write(REG_BODY_LENGTH, DATA_W'(c.body_length));
		cur = c;
	endtask

	task automatic send_frame(frame_kind_t kind);
		logic [BYTE_W-1:0] body[$];
		logic [BYTE_W-1:0] ca;
		logic [BYTE_W-1:0] cb;
		logic [15:0]       plen;
		int                span;
		int                n;
		span = cur.body_length;
		if (span < MIN_BODY)
			span = MIN_BODY;
		if (span > MAX_BODY_DEF)
			span = MAX_BODY_DEF;
		if (kind == FRM_NOISE) begin
			n = $urandom_range(1, 6);
			repeat (n)
				push_byte(($urandom_range(3) == 0) ? cur.sync_first : BYTE_W'($urandom));
			return;
		end
		push_byte(cur.sync_first);
		if (kind == FRM_BAD_SYNC) begin
			push_byte(cur.sync_second ^ BYTE_W'($urandom_range(1, 255)));
			n = $urandom_range(0, 3);
			repeat (n)
				push_byte(BYTE_W'($urandom));
			return;
		end
		push_byte(cur.sync_second);
		plen = 16'(span - 4);
		body.push_back(kind == FRM_BAD_CLASS ?
			cur.wanted_class ^ BYTE_W'($urandom_range(1, 255)) : cur.wanted_class);
		body.push_back(kind == FRM_BAD_ID ?
			cur.wanted_id ^ BYTE_W'($urandom_range(1, 255)) : cur.wanted_id);
		body.push_back(plen[7:0]);
		body.push_back(plen[15:8]);
		while (body.size() < span)
			body.push_back(BYTE_W'($urandom));
		ca = '0;
		cb = '0;
		foreach (body[i]) begin
			ca = ca + body[i];
			cb = cb + ca;
			push_byte(body[i]);
		end
		if (kind == FRM_BAD_CKA)
			ca = ca ^ BYTE_W'($urandom_range(1, 255));
		if (kind == FRM_BAD_CKB)
			cb = cb ^ BYTE_W'($urandom_range(1, 255));
		push_byte(ca);
		push_byte(cb);
	endtask

	function automatic frame_kind_t pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 64) return FRM_GOOD;
		if (r < 70) return FRM_BAD_CKA;
		if (r < 76) return FRM_BAD_CKB;
		if (r < 82) return FRM_BAD_CLASS;
		if (r < 88) return FRM_BAD_ID;
		if (r < 94) return FRM_BAD_SYNC;
		return FRM_NOISE;
	endfunction

	initial begin
		int start;
		phase_cfg[0] = '{8'hB5, 8'h62, 8'h01, 8'h07, 11'd5};
		phase_cfg[1] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 11'd4};
		phase_cfg[2] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 11'd1};
		phase_cfg[3] = '{8'hB5, 8'hB5, 8'h0A, 8'h0B, 11'd8};
		phase_cfg[4] = '{8'h55, 8'hAA, 8'h80, 8'h7F, 11'd12};
		phase_cfg[5] = '{8'hB5, 8'h62, 8'h01, 8'h07, 11'd300};
		phase_cfg[6] = '{8'h3C, 8'hC3, 8'hF0, 8'h0F, 11'd160};
		phase_cfg[7] = '{8'h01, 8'h02, 8'h01, 8'h07, 11'd96};
		phase_cfg[8] = '{8'hB5, 8'h62, 8'h01, 8'h07, 11'd6};
		cur = '{SYNC_FIRST_RST, SYNC_SECOND_RST, WANTED_CLASS_RST, WANTED_ID_RST,
			BODY_LENGTH_RST};
		gap_pct = 11;
		stall_pct = 63;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: second sync miss drops a repeated first sync, then a wrong class.
		push_byte(8'hB5);
		push_byte(8'hB5);
		push_byte(8'h62);
		push_byte(8'hB5);
		push_byte(8'h62);
		push_byte(8'h02);
		push_byte(8'h07);
		drain();
		// Length zero is raised to the minimum body.
		cfg_write(REG_BODY_LENGTH, '0);
		cur.body_length = '0;
		send_frame(FRM_GOOD);
		send_frame(FRM_BAD_CKA);
		send_frame(FRM_BAD_CKB);

		for (int p = 0; p < N_PHASES; p++) begin
			if (p < 3) begin
				gap_pct = 11;
				stall_pct = 63;
			end else if (p < 6) begin
				gap_pct = 63;
				stall_pct = 11;
			end else begin
				gap_pct = 0;
				stall_pct = 0;
			end
			drain();
			program_regs(phase_cfg[p]);
			if (phase_cfg[p].body_length >= 128) begin
				send_frame(FRM_GOOD);
			end else begin
				start = bytes_queued;
				while (bytes_queued - start < PHASE_WORDS)
					send_frame(pick_kind());
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && words_pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
src/ufr_pkg.sv
src/ufr_regs.sv
src/ufr_parser.sv
src/ubx_frame_receiver_unit.sv
sim/ufr_frame_checker.sv
sim/ubx_frame_receiver_unit_test.sv
